// ----- hdl/request_latency_histogram_macros.svh -----
// Assertion macros shared by the request latency histogram RTL.
`ifndef REQUEST_LATENCY_HISTOGRAM_MACROS_SVH
`define REQUEST_LATENCY_HISTOGRAM_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RLH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("request_latency_histogram: assertion failed");

// Next-cycle implication, checked out of reset.
`define RLH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("request_latency_histogram: assertion failed");

`endif

// ----- hdl/rlh_pkg.sv -----
// Types and constants for the request latency histogram.
`timescale 1ns / 1ps

package rlh_pkg;

	localparam int TIME_SLOTS         = 10;
	localparam int FIRST_BUCKET_SHIFT = 8;
	localparam int ACTIVE_SLOTS       = 12;
	localparam int ACTIVE_STEP        = 3;

	localparam int TS_W  = $clog2(TIME_SLOTS);
	localparam int AS_W  = $clog2(ACTIVE_SLOTS);
	localparam int POS_W = 6;   // holds 0..32
	localparam int CMP_W = 7;   // holds bin limits up to 64

	// highest-bit position at or above which the last duration bucket applies
	localparam logic [POS_W-1:0] TS_LAST_POS = POS_W'(FIRST_BUCKET_SHIFT + TIME_SLOTS - 1);
	localparam logic [POS_W-1:0] TS_SHIFT    = POS_W'(FIRST_BUCKET_SHIFT);

	localparam logic [2:0] REQ_ENTER      = 3'd0;
	localparam logic [2:0] REQ_LEAVE      = 3'd1;
	localparam logic [2:0] REQ_RECORD     = 3'd2;
	localparam logic [2:0] REQ_READ_DBIN  = 3'd3;
	localparam logic [2:0] REQ_READ_ABIN  = 3'd4;
	localparam logic [2:0] REQ_READ_TOTAL = 3'd5;
	localparam logic [2:0] REQ_READ_COUNT = 3'd6;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] duration_us;
		logic [15:0] active_count;
		logic [3:0]  bin_index;
	} rlh_req_t;

	typedef struct packed {
		logic [63:0] value;
		logic [3:0]  time_slot;
		logic [3:0]  active_slot;
		logic [15:0] active_now;
		logic        index_error;
	} rlh_rsp_t;

endpackage

// ----- hdl/request_latency_histogram.sv -----
// Request latency histogram: in-flight tracking, duration totals and two histograms.
// An accepted request is held in req_s1; its result is registered in rsp_q, which holds while rsp_stall is high.
// Throughput: one request per cycle; the only stall comes from a held result.
// Each request's update and result are computed in one pass between the two registers.
// Reset (arst_n low) clears in-flight count, totals and every histogram bin at once.
`timescale 1ns / 1ps
`include "request_latency_histogram_macros.svh"

module request_latency_histogram
	import rlh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  rlh_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output rlh_rsp_t rsp
);

	rlh_req_t    req_s1;
	logic        req_valid_s1;
	rlh_rsp_t    rsp_q;
	logic        rsp_valid_q;

	logic [63:0] total_time_q;
	logic [63:0] request_count_q;
	logic [31:0] duration_bins_q [TIME_SLOTS];
	logic [31:0] inflight_bins_q [ACTIVE_SLOTS];
	logic [15:0] inflight_q;

	logic             advance;
	logic             do_log;
	logic [31:0]      dur;
	logic [15:0]      act_src;
	logic [POS_W-1:0] top_pos;
	logic [TS_W-1:0]  ts;
	logic [AS_W-1:0]  as_slot;
	logic [15:0]      inflight_next;
	logic [TS_W-1:0]  dbin_idx;
	logic [AS_W-1:0]  abin_idx;
	logic [CMP_W-1:0] bin_idx_w;
	rlh_rsp_t         rsp_next;

	assign advance   = req_valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = req_valid_s1 && rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign dur    = req_s1.duration_us;
	assign do_log = (req_s1.req_type == REQ_LEAVE) || (req_s1.req_type == REQ_RECORD);
	// leave logs the count held before its decrement
	assign act_src = (req_s1.req_type == REQ_LEAVE) ? inflight_q : req_s1.active_count;

	// highest set bit, 1-based
	always_comb begin
		top_pos = '0;
		for (int i = 0; i < 32; i++) begin
			if (dur[i]) begin
				top_pos = POS_W'(i + 1);
			end
		end
	end

	always_comb begin
		priority if (top_pos <= TS_SHIFT) begin
			ts = '0;
		end else if (top_pos >= TS_LAST_POS) begin
			ts = TS_W'(TIME_SLOTS - 1);
		end else begin
			ts = TS_W'(top_pos - TS_SHIFT);
		end
	end

	// count / step, clamped: one threshold compare per slot above slot 0
	always_comb begin
		as_slot = '0;
		for (int k = 1; k < ACTIVE_SLOTS; k++) begin
			if (act_src >= 16'(k * ACTIVE_STEP)) begin
				as_slot = AS_W'(k);
			end
		end
	end

	always_comb begin
		inflight_next = inflight_q;
		if (req_s1.req_type == REQ_ENTER) begin
			inflight_next = inflight_q + 16'd1;
		end else if (req_s1.req_type == REQ_LEAVE && inflight_q != '0) begin
			inflight_next = inflight_q - 16'd1;
		end
	end

	assign bin_idx_w = CMP_W'(req_s1.bin_index);
	assign dbin_idx  = TS_W'(req_s1.bin_index);
	assign abin_idx  = AS_W'(req_s1.bin_index);

	always_comb begin
		rsp_next             = '0;
		rsp_next.active_now  = inflight_next;
		unique case (req_s1.req_type)
			REQ_LEAVE, REQ_RECORD: begin
				rsp_next.time_slot   = 4'(ts);
				rsp_next.active_slot = 4'(as_slot);
			end
			REQ_READ_DBIN: begin
				if (bin_idx_w < CMP_W'(TIME_SLOTS)) begin
					rsp_next.value = 64'(duration_bins_q[dbin_idx]);
				end else begin
					rsp_next.index_error = 1'b1;
				end
			end
			REQ_READ_ABIN: begin
				if (bin_idx_w < CMP_W'(ACTIVE_SLOTS)) begin
					rsp_next.value = 64'(inflight_bins_q[abin_idx]);
				end else begin
					rsp_next.index_error = 1'b1;
				end
			end
			REQ_READ_TOTAL: rsp_next.value = total_time_q;
			REQ_READ_COUNT: rsp_next.value = request_count_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			req_valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_time_q    <= '0;
			request_count_q <= '0;
			inflight_q      <= '0;
			for (int k = 0; k < TIME_SLOTS; k++) begin
				duration_bins_q[k] <= '0;
			end
			for (int k = 0; k < ACTIVE_SLOTS; k++) begin
				inflight_bins_q[k] <= '0;
			end
		end else if (advance) begin
			inflight_q <= inflight_next;
			if (do_log) begin
				total_time_q    <= total_time_q + 64'(dur);
				request_count_q <= request_count_q + 64'd1;
				// each bin checks its own slot match
				for (int k = 0; k < TIME_SLOTS; k++) begin
					if (ts == TS_W'(k)) begin
						duration_bins_q[k] <= duration_bins_q[k] + 32'd1;
					end
				end
				for (int k = 0; k < ACTIVE_SLOTS; k++) begin
					if (as_slot == AS_W'(k)) begin
						inflight_bins_q[k] <= inflight_bins_q[k] + 32'd1;
					end
				end
			end
		end
	end

	`RLH_ASSERT_IMP(a_stall_only_on_held_result, clk, arst_n,
		req_stall, rsp_valid && rsp_stall)
	`RLH_ASSERT_NXT(a_enter_bumps_inflight, clk, arst_n,
		advance && req_s1.req_type == REQ_ENTER, inflight_q == $past(inflight_q) + 16'd1)
	`RLH_ASSERT_NXT(a_log_bumps_count, clk, arst_n,
		advance && do_log, request_count_q == $past(request_count_q) + 64'd1)
	`RLH_ASSERT_IMP(a_index_error_zero_value, clk, arst_n,
		rsp_valid && rsp.index_error, rsp.value == '0)

endmodule
